// ----- rtl/core/vector3_normalize_top_assert.svh -----
// assertion macros for the vector normalizer
`ifndef VECTOR3_NORMALIZE_TOP_ASSERT_SVH
`define VECTOR3_NORMALIZE_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define V3N_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("normalizer assertion failed");

// condition must never hold
`define V3N_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("normalizer assertion failed");

`endif

// ----- rtl/core/v3n_pkg.sv -----
package v3n_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int COMP_W     = 32;
   localparam int SUM_W      = 64;
   localparam int ROOT_STEPS = SUM_W / 2;
   localparam int LEN_W      = 32;
   localparam int REM_W      = LEN_W + 1;
   localparam int QUO_W      = FRAC_BITS + 2;
   localparam int NUM_W      = COMP_W + FRAC_BITS + 1;

   // stage positions along the pipeline
   localparam int ROUND_IDX  = 3 + ROOT_STEPS;
   localparam int DIV_IDX    = ROUND_IDX + 1;
   localparam int SIDE_D     = DIV_IDX + QUO_W;

   typedef logic signed [COMP_W-1:0] comp_type;

   typedef struct packed {
      logic [2:0][COMP_W-1:0] comp;
      logic                   zero;
   } side_type;

   function automatic logic [COMP_W-1:0] mag_of(logic [COMP_W-1:0] c);
      logic [COMP_W-1:0] u;
      u = c;
      return u[COMP_W-1] ? (~u + 1'b1) : u;
   endfunction

endpackage

// ----- rtl/core/vector3_normalize_top.sv -----
// vector3_normalize_top: scales a 3-component signed fixed-point vector (one
// column of a rotation matrix, FRAC_BITS fraction bits) to unit length. The
// length is the rounded square root of the exact 64-bit sum of squares, and
// each component is divided by it with round to nearest, ties away from zero.
// An all-zero vector passes through unchanged with rsp_zero_length set.
// A word is accepted on every cycle with start high; busy is always low.
// Throughput is one word per cycle. The path runs from the input register
// through the squares, the sum, the 32 one-bit-pair square root stages, the
// rounding stage, the FRAC_BITS + 2 one-bit divider stages and the output
// register. Each result is shown for exactly one cycle on rsp_valid; the
// receiver cannot stall the pipeline.
module vector3_normalize_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [31:0]         req_comp_x,
   input  logic signed [31:0]         req_comp_y,
   input  logic signed [31:0]         req_comp_z,
   output logic                       rsp_valid,
   output logic signed [31:0]         rsp_norm_x,
   output logic signed [31:0]         rsp_norm_y,
   output logic signed [31:0]         rsp_norm_z,
   output logic                       rsp_zero_length
);

   localparam int CW = v3n_pkg::COMP_W;
   localparam int SW = v3n_pkg::SUM_W;
   localparam int LW = v3n_pkg::LEN_W;
   localparam int RW = v3n_pkg::REM_W;
   localparam int QW = v3n_pkg::QUO_W;
   localparam int NW = v3n_pkg::NUM_W;
   localparam int SD = v3n_pkg::SIDE_D;

   // valid bits and the component/zero side line that runs beside the math
   logic                vld_ff  [SD];
   v3n_pkg::side_type   side_ff [SD];
   logic                zero_in;

   // squares and sum
   logic [SW-1:0]       sq_ff [3];
   logic [SW-1:0]       sum_in;
   logic [SW-1:0]       sum_ff;

   // square root stages
   logic [SW-1:0]       root_rem_ff [v3n_pkg::ROOT_STEPS];
   logic [SW-1:0]       root_res_ff [v3n_pkg::ROOT_STEPS];

   // rounding stage
   logic [SW-1:0]       fin_rem;
   logic [SW-1:0]       fin_res;
   logic [LW-1:0]       len_in;
   logic [LW-1:0]       len_ff;
   logic [NW-1:0]       num_ff [3];

   // divider stages
   logic [RW-1:0]       drem_ff [QW][3];
   logic [QW-1:0]       dquo_ff [QW][3];
   logic [NW-1:0]       dnum_ff [QW][3];
   logic [LW-1:0]       dlen_ff [QW];

   // output register
   logic                out_vld_ff;
   logic [CW-1:0]       out_ff [3];
   logic                out_zero_ff;

   // helpers for the checks
   logic                out_all_zero;
   logic                out_x_small;

   assign busy = 1'b0;

   // ---------------- valid line ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SD; k++) vld_ff[k] <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff[0] <= start;
         for (int k = 1; k < SD; k++) vld_ff[k] <= vld_ff[k-1];
         out_vld_ff <= vld_ff[SD-1];
      end
   end

   // ---------------- side line ----------------
   assign zero_in = (sum_in == '0);

   always_ff @(posedge clock) begin
      side_ff[0].comp[0] <= req_comp_x;
      side_ff[0].comp[1] <= req_comp_y;
      side_ff[0].comp[2] <= req_comp_z;
      side_ff[0].zero    <= 1'b0;
      side_ff[1]         <= side_ff[0];
      side_ff[2].comp    <= side_ff[1].comp;
      side_ff[2].zero    <= zero_in;
      for (int k = 3; k < SD; k++) side_ff[k] <= side_ff[k-1];
   end

   // ---------------- squares, then sum ----------------
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= SW'(v3n_pkg::mag_of(side_ff[0].comp[i]))
                   * SW'(v3n_pkg::mag_of(side_ff[0].comp[i]));
      end
   end

   // at most 3 * 2^62, no carry out
   assign sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // ---------------- square root, one bit pair per stage ----------------
   for (genvar k = 0; k < v3n_pkg::ROOT_STEPS; k++) begin : g_root
      localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * k);
      logic [SW-1:0] rem_pv;
      logic [SW-1:0] res_pv;
      logic [SW-1:0] trial;

      if (k == 0) begin : g_first
         assign rem_pv = sum_ff;
         assign res_pv = '0;
      end else begin : g_next
         assign rem_pv = root_rem_ff[k-1];
         assign res_pv = root_res_ff[k-1];
      end

      assign trial = res_pv + BIT;

      always_ff @(posedge clock) begin
         if (rem_pv >= trial) begin
            root_rem_ff[k] <= rem_pv - trial;
            root_res_ff[k] <= (res_pv >> 1) + BIT;
         end else begin
            root_rem_ff[k] <= rem_pv;
            root_res_ff[k] <= res_pv >> 1;
         end
      end
   end

   // ---------------- round the root, build numerators ----------------
   assign fin_rem = root_rem_ff[v3n_pkg::ROOT_STEPS-1];
   assign fin_res = root_res_ff[v3n_pkg::ROOT_STEPS-1];
   // round up when remainder exceeds the floor root
   assign len_in  = fin_res[LW-1:0] + LW'(fin_rem > fin_res);

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      for (int i = 0; i < 3; i++) begin
         num_ff[i] <= (NW'(v3n_pkg::mag_of(side_ff[v3n_pkg::ROUND_IDX-1].comp[i]))
                       << v3n_pkg::FRAC_BITS) + NW'(len_in >> 1);
      end
   end

   // ---------------- restoring divider, one quotient bit per stage ----------------
   for (genvar j = 0; j < QW; j++) begin : g_div
      logic [RW-1:0] rem_pv [3];
      logic [QW-1:0] quo_pv [3];
      logic [NW-1:0] num_pv [3];
      logic [LW-1:0] len_pv;

      if (j == 0) begin : g_first
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               rem_pv[i] = RW'(num_ff[i] >> QW);
               quo_pv[i] = '0;
               num_pv[i] = num_ff[i];
            end
         end
         assign len_pv = len_ff;
      end else begin : g_next
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               rem_pv[i] = drem_ff[j-1][i];
               quo_pv[i] = dquo_ff[j-1][i];
               num_pv[i] = dnum_ff[j-1][i];
            end
         end
         assign len_pv = dlen_ff[j-1];
      end

      always_ff @(posedge clock) begin
         for (int i = 0; i < 3; i++) begin
            logic [RW-1:0] t;
            t = {rem_pv[i][RW-2:0], num_pv[i][QW-1-j]};
            if (t >= {1'b0, len_pv}) begin
               drem_ff[j][i] <= t - {1'b0, len_pv};
               dquo_ff[j][i] <= {quo_pv[i][QW-2:0], 1'b1};
            end else begin
               drem_ff[j][i] <= t;
               dquo_ff[j][i] <= {quo_pv[i][QW-2:0], 1'b0};
            end
            dnum_ff[j][i] <= num_pv[i];
         end
         dlen_ff[j] <= len_pv;
      end
   end

   // ---------------- sign and zero pass-through ----------------
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (side_ff[SD-1].zero) begin
            out_ff[i] <= side_ff[SD-1].comp[i];
         end else if (side_ff[SD-1].comp[i][CW-1]) begin
            out_ff[i] <= ~CW'(dquo_ff[QW-1][i]) + 1'b1;
         end else begin
            out_ff[i] <= CW'(dquo_ff[QW-1][i]);
         end
      end
      out_zero_ff <= side_ff[SD-1].zero;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_norm_x      = out_ff[0];
   assign rsp_norm_y      = out_ff[1];
   assign rsp_norm_z      = out_ff[2];
   assign rsp_zero_length = out_zero_ff;

   // ---------------- checks ----------------
   assign out_all_zero = ({rsp_norm_x, rsp_norm_y, rsp_norm_z} == '0);
   assign out_x_small  = ((rsp_norm_x >>> (QW - 1)) == 0) || ((rsp_norm_x >>> (QW - 1)) == -1);

`include "vector3_normalize_top_assert.svh"

   // zero length only comes from an all-zero vector
   `V3N_ASSERT_IMPLY(a_zero_out, rsp_valid && rsp_zero_length, out_all_zero)
   // a strobe always traces back to an accepted word
   `V3N_ASSERT_IMPLY(a_latency, rsp_valid, $past(start, SD + 1))
   // the scaled x magnitude stays below two
   `V3N_ASSERT_NEVER(a_bound, rsp_valid && !rsp_zero_length && !out_x_small)
   `V3N_ASSERT_NEVER(a_idle, busy)

endmodule

// ----- bench/vector3_normalize_checker.sv -----
`timescale 1ns / 100ps

module vector3_normalize_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [31:0] req_comp_x,
   input  logic signed [31:0] req_comp_y,
   input  logic signed [31:0] req_comp_z,
   input  logic               rsp_valid,
   input  logic signed [31:0] rsp_norm_x,
   input  logic signed [31:0] rsp_norm_y,
   input  logic signed [31:0] rsp_norm_z,
   input  logic               rsp_zero_length,
   output int                 fail_count,
   output int                 pending_count
);

   typedef struct packed {
      logic [31:0] nx;
      logic [31:0] ny;
      logic [31:0] nz;
      logic        zl;
   } unit_vec_type;

   unit_vec_type unit_queue[$];

   // rounded integer square root, bit-pair method
   function automatic logic [63:0] length_of(logic [63:0] s);
      logic [63:0] rem, res, bitv;
      rem = s;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      if (rem > res) res = res + 1;
      return res;
   endfunction

   function automatic logic [31:0] scaled_comp(logic signed [31:0] c, logic [63:0] len);
      logic [63:0] a, q;
      a = c[31] ? (64'd0 - {{32{c[31]}}, c}) : {32'd0, c};
      q = ((a << v3n_pkg::FRAC_BITS) + (len >> 1)) / len;
      if (c[31]) q = 64'd0 - q;
      return q[31:0];
   endfunction

   function automatic unit_vec_type normalize(logic signed [31:0] cx, logic signed [31:0] cy,
                                              logic signed [31:0] cz);
      logic [63:0] ax, ay, az, s, len;
      unit_vec_type r;
      ax = cx[31] ? (64'd0 - {{32{cx[31]}}, cx}) : {32'd0, cx};
      ay = cy[31] ? (64'd0 - {{32{cy[31]}}, cy}) : {32'd0, cy};
      az = cz[31] ? (64'd0 - {{32{cz[31]}}, cz}) : {32'd0, cz};
      s = ax * ax + ay * ay + az * az;
      if (s == 0) begin
         r = '{cx, cy, cz, 1'b1};
      end else begin
         len = length_of(s);
         if (len == 0) len = 1;
         r = '{scaled_comp(cx, len), scaled_comp(cy, len), scaled_comp(cz, len), 1'b0};
      end
      return r;
   endfunction

   always @(posedge clock) begin
      unit_vec_type e;
      if (!reset) begin
         if (start && !busy)
            unit_queue.push_back(normalize(req_comp_x, req_comp_y, req_comp_z));
         if (rsp_valid) begin
            if (unit_queue.size() == 0) begin
               $display("%0t: unexpected word x=%h y=%h z=%h zl=%b", $time,
                        rsp_norm_x, rsp_norm_y, rsp_norm_z, rsp_zero_length);
               fail_count++;
            end else begin
               e = unit_queue.pop_front();
               if (e.nx !== rsp_norm_x || e.ny !== rsp_norm_y || e.nz !== rsp_norm_z
                   || e.zl !== rsp_zero_length) begin
                  $display(
                     "%0t: mismatch expected x=%h y=%h z=%h zl=%b actual x=%h y=%h z=%h zl=%b",
                     $time, e.nx, e.ny, e.nz, e.zl,
                     rsp_norm_x, rsp_norm_y, rsp_norm_z, rsp_zero_length);
                  fail_count++;
               end
            end
         end
      end
      pending_count = unit_queue.size();
   end
endmodule

// ----- bench/tb_vector3_normalize_top.sv -----
`timescale 1ns / 100ps

module tb_vector3_normalize_top;

   localparam int NUM_RANDOM  = 1600;
   localparam int CYCLE_LIMIT = 200000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_comp_x, req_comp_y, req_comp_z;
   logic               rsp_valid;
   logic signed [31:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic               rsp_zero_length;
   int                 fail_count;
   int                 pending_count;
   int                 cycle_count;

   vector3_normalize_top DUT (.*);

   vector3_normalize_checker checker_inst (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // random component, biased toward interesting magnitudes
   function automatic logic [31:0] pick_comp();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 7) - 3;                   // tiny, short vectors
         2: return ($urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000); // +-1.0
         3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)}; // within +-1.0
         4: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         default: return $signed($urandom) >>> $urandom_range(0, 31);
      endcase
   endfunction

   // hand one word to the block, holding start until it is taken
   task automatic send_word(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      start      <= 1'b1;
      req_comp_x <= x;
      req_comp_y <= y;
      req_comp_z <= z;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_gap(bit quiet);
      if (!quiet && $urandom_range(0, 99) < 10) begin
         start <= 1'b0;
         req_comp_x <= $urandom;  // junk while idle
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   initial begin
      start      = 0;
      req_comp_x = 0;
      req_comp_y = 0;
      req_comp_z = 0;
      reset      = 1;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: zero length, extremes, unit axes, short vectors
      send_word(32'h0, 32'h0, 32'h0);
      send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_word(32'h8000_0000, 32'h0, 32'h0);
      send_word(32'h0, 32'h7fff_ffff, 32'h0);
      send_word(32'h0, 32'h0, 32'h8000_0000);
      send_word(32'h0001_0000, 32'h0, 32'h0);
      send_word(32'h0, 32'hffff_0000, 32'h0);
      send_word(32'h1, 32'h1, 32'h0);
      send_word(32'hffff_ffff, 32'h1, 32'hffff_ffff);
      send_word(32'h0, 32'h0, 32'h1);
      send_word(32'hffff_ffff, 32'h0, 32'h0);
      send_word(32'h0, 32'h0, 32'h0);
      send_word(32'h7fff_ffff, 32'h8000_0000, 32'h1);
      send_word(32'h0000_b505, 32'hffff_4afb, 32'h0);  // near 45 degrees
      send_word(32'h5555_5555, 32'haaaa_aaaa, 32'hffff_ffff);

      // random, with a quiet stretch in the middle
      for (int i = 0; i < NUM_RANDOM; i++) begin
         idle_gap(i >= 600 && i < 900);
         if ($urandom_range(0, 49) == 0)
            send_word(32'h0, 32'h0, 32'h0);
         else
            send_word(pick_comp(), pick_comp(), pick_comp());
      end
      start <= 1'b0;

      // drain the pipeline, then allow a little extra
      while (pending_count != 0) @(posedge clock);
      repeat (v3n_pkg::SIDE_D + 10) @(posedge clock);

      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/v3n_pkg.sv
rtl/core/vector3_normalize_top.sv
bench/vector3_normalize_checker.sv
bench/tb_vector3_normalize_top.sv
